### sv/gpp_pkg.sv
package gpp_pkg;

  localparam int AMB_W      = 16;
  localparam int FRAC_W     = 10;
  localparam int MODE_W     = 2;
  localparam int QUOT_W     = 16;
  localparam int PROD_W     = 26;
  localparam int NUM_W      = 52;
  localparam int DIV_W      = 36;
  localparam int DROP_W     = 46;
  localparam int SCALE_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RATIO_W    = 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic [FRAC_W-1:0]  FULL_PERMILLE = 10'd1000;
  localparam logic [SCALE_W-1:0] DROP_SCALE    = 20'd1000000;

  localparam logic [MODE_W-1:0] MODE_OC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PSCR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CONS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd2;

  localparam logic [CFG_DATA_W-1:0] CONS_RESET  = 16'd720;
  localparam logic [CFG_DATA_W-1:0] RATE_RESET  = 16'd20000;
  localparam logic [RATIO_W-1:0]    RATIO_RESET = 10'd100;

  typedef enum logic [1:0] {
    CLS_OC,
    CLS_SENSOR,
    CLS_SCR
  } gpp_class_t;

  typedef struct packed {
    logic [AMB_W-1:0]  ambient_mbar;
    logic [FRAC_W-1:0] oxygen_permille;
    logic [FRAC_W-1:0] helium_permille;
    logic [AMB_W-1:0]  sensor_po2_mbar;
    logic [MODE_W-1:0] dive_mode;
  } gpp_sample_t;

  typedef struct packed {
    logic [AMB_W-1:0] oxygen_mbar;
    logic [AMB_W-1:0] helium_mbar;
    logic [AMB_W-1:0] nitrogen_mbar;
  } gpp_result_t;

  typedef struct packed {
    logic [AMB_W-1:0]  amb;
    logic [AMB_W-1:0]  po2;
    logic [FRAC_W-1:0] o2f;
    logic [FRAC_W-1:0] hef;
    logic [FRAC_W-1:0] n2f;
    logic [FRAC_W-1:0] den;
    gpp_class_t        cls;
  } gpp_mix_t;

  typedef struct packed {
    logic [NUM_W-1:0] numer;
    logic [DIV_W-1:0] divisor;
    gpp_mix_t         mix;
  } gpp_work_t;

endpackage

### sv/gpp_fifo.sv
module gpp_fifo #(
  parameter int DEPTH = 4,
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  T     wr_data,
  input  logic rd_en,
  output T     rd_data,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  count;
  logic           wr;
  logic           rd;

  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/gpp_front.sv
module gpp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  gpp_pkg::gpp_sample_t               sample,
  input  logic                               stall,
  input  logic                               cfg_write,
  input  logic [gpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output gpp_pkg::gpp_work_t                 work,
  output logic                               work_wr
);

  logic [gpp_pkg::CFG_DATA_W-1:0] cons;
  logic [gpp_pkg::CFG_DATA_W-1:0] rate;
  logic [gpp_pkg::RATIO_W-1:0]    ratio;

  logic                       v1, v2, v3, v4;
  gpp_pkg::gpp_mix_t          mix_c, m1, m2, m3;
  logic [gpp_pkg::PROD_W-1:0] oa2, prod2, dc2, oa3;
  logic [gpp_pkg::NUM_W-1:0]  gain3;
  logic [gpp_pkg::DROP_W-1:0] drop3;
  logic [gpp_pkg::DIV_W-1:0]  dv3;
  logic                       pz3;
  gpp_pkg::gpp_work_t         work_c, w4;
  logic                       accept;

  assign accept  = push && !stall;
  assign work    = w4;
  assign work_wr = v4 && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cons  <= gpp_pkg::CONS_RESET;
      rate  <= gpp_pkg::RATE_RESET;
      ratio <= gpp_pkg::RATIO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        gpp_pkg::REG_CONS:  cons  <= cfg_data;
        gpp_pkg::REG_RATE:  rate  <= cfg_data;
        gpp_pkg::REG_RATIO: ratio <= cfg_data[gpp_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the mix and sort the item into its pressure model
  always_comb begin
    mix_c.amb = sample.ambient_mbar;
    mix_c.po2 = sample.sensor_po2_mbar;
    mix_c.o2f = (sample.oxygen_permille > gpp_pkg::FULL_PERMILLE) ?
                gpp_pkg::FULL_PERMILLE : sample.oxygen_permille;
    mix_c.den = gpp_pkg::FULL_PERMILLE - mix_c.o2f;
    mix_c.hef = (sample.helium_permille > mix_c.den) ? mix_c.den : sample.helium_permille;
    mix_c.n2f = mix_c.den - mix_c.hef;
    if (sample.dive_mode != gpp_pkg::MODE_OC && sample.sensor_po2_mbar != '0) begin
      mix_c.cls = gpp_pkg::CLS_SENSOR;
    end else if (sample.dive_mode == gpp_pkg::MODE_PSCR) begin
      mix_c.cls = gpp_pkg::CLS_SCR;
    end else begin
      mix_c.cls = gpp_pkg::CLS_OC;
    end
  end

  // steady-state oxygen numerator and divisor; all but SCR with a nonzero rate-ratio product divide by 1000
  always_comb begin
    work_c.mix = m3;
    if (m3.cls == gpp_pkg::CLS_SCR && !pz3) begin
      work_c.numer   = (gain3 > gpp_pkg::NUM_W'(drop3)) ?
                       gain3 - gpp_pkg::NUM_W'(drop3) : '0;
      work_c.divisor = dv3;
    end else begin
      work_c.numer   = gpp_pkg::NUM_W'(oa3);
      work_c.divisor = gpp_pkg::DIV_W'(gpp_pkg::FULL_PERMILLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (!stall) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      m1    <= mix_c;
      m2    <= m1;
      oa2   <= gpp_pkg::PROD_W'(m1.o2f) * gpp_pkg::PROD_W'(m1.amb);
      prod2 <= gpp_pkg::PROD_W'(rate) * gpp_pkg::PROD_W'(ratio);
      dc2   <= gpp_pkg::PROD_W'(m1.den) * gpp_pkg::PROD_W'(cons);
      m3    <= m2;
      oa3   <= oa2;
      gain3 <= gpp_pkg::NUM_W'(oa2) * gpp_pkg::NUM_W'(prod2);
      drop3 <= gpp_pkg::DROP_W'(dc2) * gpp_pkg::DROP_W'(gpp_pkg::DROP_SCALE);
      dv3   <= gpp_pkg::DIV_W'(prod2) * gpp_pkg::DIV_W'(gpp_pkg::FULL_PERMILLE);
      pz3   <= prod2 == '0;
      w4    <= work_c;
    end
  end

endmodule

### sv/gpp_back.sv
module gpp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  gpp_pkg::gpp_work_t   work,
  input  logic                 avail,
  output logic                 take,
  input  logic                 res_full,
  output gpp_pkg::gpp_result_t result,
  output logic                 res_wr
);

  localparam int OX_STAGES = gpp_pkg::QUOT_W;
  localparam int SD_STAGES = gpp_pkg::QUOT_W / 2;

  logic adv;

  logic                        ox_v [OX_STAGES+1];
  gpp_pkg::gpp_work_t          ox_w [OX_STAGES+1];
  logic [gpp_pkg::QUOT_W-1:0]  ox_q [OX_STAGES+1];

  logic                        r_v;
  logic [gpp_pkg::AMB_W-1:0]   r_o2, r_rest, o2_c, rest_c;
  logic [gpp_pkg::FRAC_W-1:0]  r_hef, r_n2f, r_d2, d2_c;

  logic                        sd_v  [SD_STAGES+1];
  logic [gpp_pkg::AMB_W-1:0]   sd_o2 [SD_STAGES+1];
  logic [gpp_pkg::PROD_W-1:0]  sd_h  [SD_STAGES+1];
  logic [gpp_pkg::PROD_W-1:0]  sd_n  [SD_STAGES+1];
  logic [gpp_pkg::FRAC_W-1:0]  sd_d  [SD_STAGES+1];
  logic [gpp_pkg::QUOT_W-1:0]  sd_qh [SD_STAGES+1];
  logic [gpp_pkg::QUOT_W-1:0]  sd_qn [SD_STAGES+1];

  assign adv  = !res_full;
  assign take = adv && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= OX_STAGES; k++) ox_v[k] <= 1'b0;
      for (int k = 0; k <= SD_STAGES; k++) sd_v[k] <= 1'b0;
      r_v <= 1'b0;
    end else if (adv) begin
      ox_v[0] <= avail;
      for (int k = 0; k < OX_STAGES; k++) ox_v[k+1] <= ox_v[k];
      r_v     <= ox_v[OX_STAGES];
      sd_v[0] <= r_v;
      for (int k = 0; k < SD_STAGES; k++) sd_v[k+1] <= sd_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_w[0] <= work;
      ox_q[0] <= '0;
    end
  end

  // oxygen quotient, one bit per stage
  for (genvar k = 0; k < OX_STAGES; k++) begin : g_ox
    localparam int SH = gpp_pkg::QUOT_W - 1 - k;
    logic [gpp_pkg::NUM_W-1:0]  dsh;
    gpp_pkg::gpp_work_t         w_next;
    logic [gpp_pkg::QUOT_W-1:0] q_next;
    assign dsh = gpp_pkg::NUM_W'(ox_w[k].divisor) << SH;
    always_comb begin
      w_next = ox_w[k];
      q_next = ox_q[k];
      if (ox_w[k].numer >= dsh) begin
        w_next.numer = ox_w[k].numer - dsh;
        q_next       = ox_q[k] | (gpp_pkg::QUOT_W'(1) << SH);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ox_w[k+1] <= w_next;
        ox_q[k+1] <= q_next;
      end
    end
  end

  // pick the oxygen value and the pressure left for the inert gases
  always_comb begin
    d2_c = (ox_w[OX_STAGES].mix.den == '0) ? gpp_pkg::FRAC_W'(1) : ox_w[OX_STAGES].mix.den;
    case (ox_w[OX_STAGES].mix.cls)
      gpp_pkg::CLS_SENSOR: begin
        if (ox_w[OX_STAGES].mix.po2 >= ox_w[OX_STAGES].mix.amb) begin
          o2_c   = ox_w[OX_STAGES].mix.amb;
          rest_c = '0;
        end else begin
          o2_c   = ox_w[OX_STAGES].mix.po2;
          rest_c = ox_w[OX_STAGES].mix.amb - ox_w[OX_STAGES].mix.po2;
        end
      end
      gpp_pkg::CLS_SCR: begin
        o2_c   = ox_q[OX_STAGES];
        rest_c = ox_w[OX_STAGES].mix.amb - ox_q[OX_STAGES];
      end
      default: begin
        o2_c   = ox_q[OX_STAGES];
        rest_c = ox_w[OX_STAGES].mix.amb;
        d2_c   = gpp_pkg::FULL_PERMILLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_o2     <= o2_c;
      r_rest   <= rest_c;
      r_hef    <= ox_w[OX_STAGES].mix.hef;
      r_n2f    <= ox_w[OX_STAGES].mix.n2f;
      r_d2     <= d2_c;
      sd_o2[0] <= r_o2;
      sd_h[0]  <= gpp_pkg::PROD_W'(r_rest) * gpp_pkg::PROD_W'(r_hef);
      sd_n[0]  <= gpp_pkg::PROD_W'(r_rest) * gpp_pkg::PROD_W'(r_n2f);
      sd_d[0]  <= r_d2;
      sd_qh[0] <= '0;
      sd_qn[0] <= '0;
    end
  end

  // helium and nitrogen quotients, two bits per stage
  for (genvar k = 0; k < SD_STAGES; k++) begin : g_sd
    localparam int SH1 = gpp_pkg::QUOT_W - 1 - 2 * k;
    localparam int SH0 = SH1 - 1;
    logic [gpp_pkg::PROD_W-1:0] d1, d0, h1, n1, h0, n0;
    logic [gpp_pkg::QUOT_W-1:0] qh0, qn0;
    always_comb begin
      d1  = gpp_pkg::PROD_W'(sd_d[k]) << SH1;
      d0  = gpp_pkg::PROD_W'(sd_d[k]) << SH0;
      qh0 = sd_qh[k];
      qn0 = sd_qn[k];
      h1  = sd_h[k];
      n1  = sd_n[k];
      if (sd_h[k] >= d1) begin
        h1  = sd_h[k] - d1;
        qh0 = qh0 | (gpp_pkg::QUOT_W'(1) << SH1);
      end
      if (sd_n[k] >= d1) begin
        n1  = sd_n[k] - d1;
        qn0 = qn0 | (gpp_pkg::QUOT_W'(1) << SH1);
      end
      h0 = h1;
      n0 = n1;
      if (h1 >= d0) begin
        h0  = h1 - d0;
        qh0 = qh0 | (gpp_pkg::QUOT_W'(1) << SH0);
      end
      if (n1 >= d0) begin
        n0  = n1 - d0;
        qn0 = qn0 | (gpp_pkg::QUOT_W'(1) << SH0);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sd_o2[k+1] <= sd_o2[k];
        sd_d[k+1]  <= sd_d[k];
        sd_h[k+1]  <= h0;
        sd_n[k+1]  <= n0;
        sd_qh[k+1] <= qh0;
        sd_qn[k+1] <= qn0;
      end
    end
  end

  assign res_wr               = sd_v[SD_STAGES] && adv;
  assign result.oxygen_mbar   = sd_o2[SD_STAGES];
  assign result.helium_mbar   = sd_qh[SD_STAGES];
  assign result.nitrogen_mbar = sd_qn[SD_STAGES];

endmodule

### sv/gas_partial_pressure_unit.sv
// channel  | handshake    | payload
// ---------+--------------+-----------------------------------------------
// input    | push / full  | sample : gpp_sample_t
// result   | pop / empty  | result : gpp_result_t
// config   | cfg_write    | cfg_index, cfg_data (no wait, no read-back)
//
// One item per cycle sustained while neither queue is full. From transfer in to
// result at the head of the output queue an item passes 4 front stages, the
// classified item queue, the bit-per-stage oxygen divider, 1 select stage,
// 1 multiply stage and 8 stages of the two-bit-per-stage inert gas dividers.
// Reset is synchronous and empties both queues and all pipeline valids.
// The front stalls only when its queue is full, the back only when the
// output queue is full.
module gas_partial_pressure_unit #(
  parameter int QUEUE_DEPTH = gpp_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = gpp_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  gpp_pkg::gpp_sample_t           sample,
  output logic                           empty,
  input  logic                           pop,
  output gpp_pkg::gpp_result_t           result,
  input  logic                           cfg_write,
  input  logic [gpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpp_pkg::CFG_DATA_W-1:0] cfg_data
);

  gpp_pkg::gpp_work_t   q_in, q_out;
  logic                 q_wr, q_full, q_empty, q_rd;
  gpp_pkg::gpp_result_t res;
  logic                 out_wr, out_full;

  assign full = q_full;

  gpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .stall     (q_full),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .work      (q_in),
    .work_wr   (q_wr)
  );

  gpp_fifo #(.DEPTH(QUEUE_DEPTH), .T(gpp_pkg::gpp_work_t)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_in),
    .rd_en   (q_rd),
    .rd_data (q_out),
    .empty   (q_empty),
    .full    (q_full)
  );

  gpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .work     (q_out),
    .avail    (!q_empty),
    .take     (q_rd),
    .res_full (out_full),
    .result   (res),
    .res_wr   (out_wr)
  );

  gpp_fifo #(.DEPTH(OUT_DEPTH), .T(gpp_pkg::gpp_result_t)) u_out (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty),
    .full    (out_full)
  );

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_full) else $error("item queue written while full");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> !out_full) else $error("output queue written while full");

  a_sum_fits: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({2'b00, result.oxygen_mbar} + {2'b00, result.helium_mbar}
                + {2'b00, result.nitrogen_mbar}) <= 18'd65535)
    else $error("partial pressures exceed ambient range");
`endif

endmodule
